// File: design/imq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imq_pkg
// Shared widths, codes and the heap entry type of the indexed min-heap queue.
// ----------------------------------------------------------------------------
package imq_pkg;

    localparam int FUNC_W   = 2;
    localparam int ID_W     = 10;
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 32;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 9;

    localparam int CAPACITY_DEF = 256;
    localparam int ID_SPACE_DEF = 1024;

    localparam logic [CFG_W-1:0] CAP_LIMIT_RESET = 9'd256;

    localparam logic [FUNC_W-1:0] FN_INSERT  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_DEL_MIN = 2'd1;
    localparam logic [FUNC_W-1:0] FN_SET_KEY = 2'd2;
    localparam logic [FUNC_W-1:0] FN_REMOVE  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
        logic [PAY_W-1:0] payload;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: design/imq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module imq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/indexed_min_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_priority_queue
// Binary min-heap of (id, key, payload) entries with an id-to-slot table,
// worked by a small sequencer around one shared signed key comparator.
// ----------------------------------------------------------------------------
// Throughput: one request at a time; a new request is taken only after the
//   previous result has been presented, and a stalled result holds the block.
//   Each sift level needs its own heap RAM reads.
// After reset the whole slot table (ID_SPACE entries, 1024 by default) is
//   cleared before the first request is taken; configuration writes are
//   taken at any time.
module indexed_min_priority_queue #(
    parameter int CAPACITY = imq_pkg::CAPACITY_DEF,
    parameter int ID_SPACE = imq_pkg::ID_SPACE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [imq_pkg::CFG_W-1:0]           cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [imq_pkg::FUNC_W-1:0]          func,
    input  logic [imq_pkg::ID_W-1:0]            entry_id,
    input  logic signed [imq_pkg::KEY_W-1:0]    entry_key,
    input  logic [imq_pkg::PAY_W-1:0]           entry_payload,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [imq_pkg::STATUS_W-1:0]        status,
    output logic [imq_pkg::ID_W-1:0]            out_id,
    output logic signed [imq_pkg::KEY_W-1:0]    out_key,
    output logic [imq_pkg::PAY_W-1:0]           out_payload
);

    localparam int SW  = $clog2(CAPACITY + 1);
    localparam int IDW = (ID_SPACE > 1) ? $clog2(ID_SPACE) : 1;
    localparam int RECIP_SH = 2 * imq_pkg::ID_W;
    localparam int RECIP    = ((1 << RECIP_SH) + ID_SPACE - 1) / ID_SPACE;

    typedef enum logic [14:0] {
        S_CLR    = 15'b000000000000001,
        S_IDLE   = 15'b000000000000010,
        S_CHECK  = 15'b000000000000100,
        S_SK_CUR = 15'b000000000001000,
        S_TO_OUT = 15'b000000000010000,
        S_TO_LST = 15'b000000000100000,
        S_SD_L   = 15'b000000001000000,
        S_SD_R   = 15'b000000010000000,
        S_SD_C   = 15'b000000100000000,
        S_SD_MV  = 15'b000001000000000,
        S_SU_RD  = 15'b000010000000000,
        S_SU_CMP = 15'b000100000000000,
        S_FIN    = 15'b001000000000000,
        S_RES    = 15'b010000000000000,
        S_SPARE  = 15'b100000000000000
    } state_t;

    // Reduces an id modulo ID_SPACE by a rounded-up reciprocal multiplication,
    // which gives the exact quotient for every id of ID_W bits.
    function automatic logic [imq_pkg::ID_W-1:0] wrap_id(input logic [imq_pkg::ID_W-1:0] v);
        logic [31:0] q;
        logic [31:0] r;
        q = (32'(v) * 32'(RECIP)) >> RECIP_SH;
        r = 32'(v) - q * 32'(ID_SPACE);
        if (ID_SPACE >= (1 << imq_pkg::ID_W))
        begin
            r = 32'(v);
        end
        return r[imq_pkg::ID_W-1:0];
    endfunction

    function automatic logic [IDW-1:0] slot_addr(input logic [imq_pkg::ID_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[IDW-1:0];
    endfunction

    state_t state_reg, state_next;
    logic [imq_pkg::CFG_W-1:0] cap_reg, cap_next;
    logic [SW-1:0] count_reg, count_next;
    logic [SW-1:0] pos_reg, pos_next;
    logic [SW-1:0] sel_reg, sel_next;
    logic          moved_reg, moved_next;
    logic [IDW-1:0] clr_reg, clr_next;
    logic          ovalid_reg, ovalid_next;

    logic [imq_pkg::FUNC_W-1:0] func_reg, func_next;
    logic [imq_pkg::ID_W-1:0]   id_reg, id_next;
    logic [imq_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [imq_pkg::PAY_W-1:0]  pay_reg, pay_next;
    imq_pkg::entry_t            cur_reg, cur_next;
    imq_pkg::entry_t            best_reg, best_next;
    logic [imq_pkg::STATUS_W-1:0] rstat_reg, rstat_next;
    imq_pkg::entry_t            rent_reg, rent_next;
    logic [imq_pkg::STATUS_W-1:0] ostat_reg, ostat_next;
    imq_pkg::entry_t            oent_reg, oent_next;

    logic            heap_we;
    logic [SW-1:0]   heap_waddr, heap_raddr;
    imq_pkg::entry_t heap_wdata, heap_rdata;
    logic            slot_we;
    logic [IDW-1:0]  slot_waddr, slot_raddr;
    logic [SW-1:0]   slot_wdata, slot_rdata;

    logic [imq_pkg::KEY_W-1:0] cmp_a, cmp_b;
    logic            cmp_less;
    logic [31:0]     cap_eff;
    logic            is_full;
    logic            slot_bad;
    logic [SW:0]     lchild, rchild, last_old;

    imq_ram #(.WIDTH(imq_pkg::ENTRY_W), .DEPTH(CAPACITY + 1)) u_heap_ram (
        .clk   (clk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    imq_ram #(.WIDTH(SW), .DEPTH(ID_SPACE)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    // The one key comparator, shared by every compare step of both sifts.
    always_comb
    begin
        case (state_reg)
            S_SU_CMP:
            begin
                cmp_a = cur_reg.key;
                cmp_b = heap_rdata.key;
            end
            S_SD_R:
            begin
                cmp_a = heap_rdata.key;
                cmp_b = cur_reg.key;
            end
            default:
            begin
                cmp_a = heap_rdata.key;
                cmp_b = best_reg.key;
            end
        endcase
    end

    assign cmp_less = $signed(cmp_a) < $signed(cmp_b);

    assign cap_eff  = (32'(cap_reg) > 32'(CAPACITY)) ? 32'(CAPACITY) : 32'(cap_reg);
    assign is_full  = 32'(count_reg) >= cap_eff;
    assign slot_bad = (slot_rdata == '0) || (slot_rdata > count_reg);
    assign lchild   = {pos_reg, 1'b0};
    assign rchild   = {pos_reg, 1'b1};
    assign last_old = {1'b0, count_reg} + 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        cap_next    = cap_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        sel_next    = sel_reg;
        moved_next  = moved_reg;
        clr_next    = clr_reg;
        ovalid_next = ovalid_reg;
        func_next   = func_reg;
        id_next     = id_reg;
        key_next    = key_reg;
        pay_next    = pay_reg;
        cur_next    = cur_reg;
        best_next   = best_reg;
        rstat_next  = rstat_reg;
        rent_next   = rent_reg;
        ostat_next  = ostat_reg;
        oent_next   = oent_reg;

        heap_we    = 1'b0;
        heap_waddr = pos_reg;
        heap_wdata = cur_reg;
        heap_raddr = pos_reg;
        slot_we    = 1'b0;
        slot_waddr = slot_addr(cur_reg.id);
        slot_wdata = pos_reg;
        slot_raddr = slot_addr(wrap_id(entry_id));

        if (cfg_wr_en)
        begin
            cap_next = cfg_wr_data;
        end

        if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_CLR:
            begin
                slot_we    = 1'b1;
                slot_waddr = clr_reg;
                slot_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == IDW'(ID_SPACE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    id_next    = wrap_id(entry_id);
                    key_next   = entry_key;
                    pay_next   = entry_payload;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                rent_next  = '0;
                rstat_next = imq_pkg::ST_OK;
                moved_next = 1'b0;
                case (func_reg)
                    imq_pkg::FN_INSERT:
                    begin
                        if (is_full)
                        begin
                            rstat_next = imq_pkg::ST_FULL;
                            state_next = S_RES;
                        end
                        else if (slot_rdata != '0)
                        begin
                            rstat_next = imq_pkg::ST_PRESENT;
                            state_next = S_RES;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                            pos_next   = count_reg + 1'b1;
                            cur_next   = '{key: key_reg, id: id_reg, payload: pay_reg};
                            state_next = S_SU_RD;
                        end
                    end
                    imq_pkg::FN_DEL_MIN:
                    begin
                        if (count_reg == '0)
                        begin
                            rstat_next = imq_pkg::ST_EMPTY;
                            state_next = S_RES;
                        end
                        else
                        begin
                            heap_raddr = SW'(1);
                            pos_next   = SW'(1);
                            state_next = S_TO_OUT;
                        end
                    end
                    imq_pkg::FN_SET_KEY:
                    begin
                        if (slot_bad)
                        begin
                            rstat_next = imq_pkg::ST_NOTFOUND;
                            state_next = S_RES;
                        end
                        else
                        begin
                            heap_raddr = slot_rdata;
                            pos_next   = slot_rdata;
                            state_next = S_SK_CUR;
                        end
                    end
                    default:
                    begin
                        if (slot_bad)
                        begin
                            rstat_next = imq_pkg::ST_NOTFOUND;
                            state_next = S_RES;
                        end
                        else
                        begin
                            heap_raddr = slot_rdata;
                            pos_next   = slot_rdata;
                            state_next = S_TO_OUT;
                        end
                    end
                endcase
            end
            S_SK_CUR:
            begin
                cur_next   = '{key: key_reg, id: heap_rdata.id, payload: heap_rdata.payload};
                state_next = S_SD_L;
            end
            S_TO_OUT:
            begin
                // The departing entry's id is marked absent and the last slot is fetched.
                rent_next  = heap_rdata;
                heap_raddr = count_reg;
                slot_we    = 1'b1;
                slot_waddr = slot_addr(heap_rdata.id);
                slot_wdata = '0;
                count_next = count_reg - 1'b1;
                state_next = S_TO_LST;
            end
            S_TO_LST:
            begin
                if ({1'b0, pos_reg} == last_old)
                begin
                    state_next = S_RES;
                end
                else
                begin
                    cur_next   = heap_rdata;
                    state_next = S_SD_L;
                end
            end
            S_SD_L:
            begin
                if (lchild <= {1'b0, count_reg})
                begin
                    heap_raddr = lchild[SW-1:0];
                    state_next = S_SD_R;
                end
                else
                begin
                    state_next = moved_reg ? S_FIN : S_SU_RD;
                end
            end
            S_SD_R:
            begin
                if (cmp_less)
                begin
                    best_next = heap_rdata;
                    sel_next  = lchild[SW-1:0];
                end
                else
                begin
                    best_next = cur_reg;
                    sel_next  = pos_reg;
                end
                if (rchild <= {1'b0, count_reg})
                begin
                    heap_raddr = rchild[SW-1:0];
                    state_next = S_SD_C;
                end
                else
                begin
                    state_next = S_SD_MV;
                end
            end
            S_SD_C:
            begin
                if (cmp_less)
                begin
                    best_next = heap_rdata;
                    sel_next  = rchild[SW-1:0];
                end
                state_next = S_SD_MV;
            end
            S_SD_MV:
            begin
                if (sel_reg == pos_reg)
                begin
                    state_next = moved_reg ? S_FIN : S_SU_RD;
                end
                else
                begin
                    // The smaller child rises into the hole, which moves down.
                    heap_we    = 1'b1;
                    heap_wdata = best_reg;
                    slot_we    = 1'b1;
                    slot_waddr = slot_addr(best_reg.id);
                    pos_next   = sel_reg;
                    moved_next = 1'b1;
                    state_next = S_SD_L;
                end
            end
            S_SU_RD:
            begin
                if (pos_reg > SW'(1))
                begin
                    heap_raddr = pos_reg >> 1;
                    state_next = S_SU_CMP;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_SU_CMP:
            begin
                if (cmp_less)
                begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rdata;
                    slot_we    = 1'b1;
                    slot_waddr = slot_addr(heap_rdata.id);
                    pos_next   = pos_reg >> 1;
                    state_next = S_SU_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                heap_we    = 1'b1;
                slot_we    = 1'b1;
                state_next = S_RES;
            end
            S_RES:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = rstat_reg;
                    oent_next   = rent_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            cap_reg    <= imq_pkg::CAP_LIMIT_RESET;
            count_reg  <= '0;
            pos_reg    <= '0;
            sel_reg    <= '0;
            moved_reg  <= 1'b0;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cap_reg    <= cap_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
            sel_reg    <= sel_next;
            moved_reg  <= moved_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        id_reg    <= id_next;
        key_reg   <= key_next;
        pay_reg   <= pay_next;
        cur_reg   <= cur_next;
        best_reg  <= best_next;
        rstat_reg <= rstat_next;
        rent_reg  <= rent_next;
        ostat_reg <= ostat_next;
        oent_reg  <= oent_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = ovalid_reg;
    assign status      = ostat_reg;
    assign out_id      = oent_reg.id;
    assign out_key     = oent_reg.key;
    assign out_payload = oent_reg.payload;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives insert, delete-minimum, set-key and remove requests into the indexed
// min-heap queue under random gaps and output stalls, and checks every result
// transfer against the typed result or a behavioural heap kept alongside.
// ----------------------------------------------------------------------------
module testbench;

    localparam int HEAP_CAP  = 256;
    localparam int IDS       = 1024;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef logic [imq_pkg::FUNC_W-1:0]   fn_t;
    typedef logic [imq_pkg::ID_W-1:0]     id_t;
    typedef logic [imq_pkg::KEY_W-1:0]    key_t;
    typedef logic [imq_pkg::PAY_W-1:0]    pay_t;
    typedef logic [imq_pkg::STATUS_W-1:0] st_t;

    typedef struct packed {
        st_t  st;
        id_t  id;
        key_t key;
        pay_t pay;
    } status_word_t;

    typedef struct {
        fn_t          fn;
        id_t          id;
        key_t         key;
        pay_t         pay;
        bit           known;
        status_word_t res;
    } request_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [imq_pkg::CFG_W-1:0] cfg_wr_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    fn_t func = '0;
    id_t entry_id = '0;
    logic signed [imq_pkg::KEY_W-1:0] entry_key = '0;
    pay_t entry_payload = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    st_t status;
    id_t out_id;
    logic signed [imq_pkg::KEY_W-1:0] out_key;
    pay_t out_payload;

    // Shadow heap, slots 1..heap_size.
    key_t hp_key [1:HEAP_CAP];
    id_t  hp_id  [1:HEAP_CAP];
    pay_t hp_pay [1:HEAP_CAP];
    int unsigned slot_by_id [IDS];
    int unsigned heap_size;
    int unsigned cap_reg;

    status_word_t pending_status [$];
    request_row_t directed_rows [$];
    int mismatches = 0;
    int transfers_out = 0;
    int transfers_in = 0;
    longint cycles = 0;

    indexed_min_priority_queue i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .entry_id(entry_id), .entry_key(entry_key),
        .entry_payload(entry_payload),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .out_id(out_id), .out_key(out_key),
        .out_payload(out_payload)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic bit lower_key(key_t a, key_t b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic void exchange_slots(int unsigned a, int unsigned b);
        key_t k;
        id_t i;
        pay_t p;
        k = hp_key[a]; hp_key[a] = hp_key[b]; hp_key[b] = k;
        i = hp_id[a]; hp_id[a] = hp_id[b]; hp_id[b] = i;
        p = hp_pay[a]; hp_pay[a] = hp_pay[b]; hp_pay[b] = p;
        slot_by_id[hp_id[a]] = a;
        slot_by_id[hp_id[b]] = b;
    endfunction

    function automatic void bubble_up(int unsigned pos);
        while (pos > 1 && lower_key(hp_key[pos], hp_key[pos / 2]))
        begin
            exchange_slots(pos, pos / 2);
            pos = pos / 2;
        end
    endfunction

    function automatic bit bubble_down(int unsigned pos);
        int unsigned l;
        int unsigned s;
        bit moved;
        moved = 1'b0;
        while (pos <= heap_size / 2)
        begin
            l = 2 * pos;
            s = pos;
            if (l <= heap_size && lower_key(hp_key[l], hp_key[s]))
                s = l;
            if (l + 1 <= heap_size && lower_key(hp_key[l + 1], hp_key[s]))
                s = l + 1;
            if (s == pos)
                break;
            exchange_slots(pos, s);
            pos = s;
            moved = 1'b1;
        end
        return moved;
    endfunction

    function automatic void reheap_at(int unsigned pos);
        if (!bubble_down(pos))
            bubble_up(pos);
    endfunction

    function automatic status_word_t extract_slot(int unsigned pos);
        status_word_t r;
        int unsigned last;
        last = heap_size;
        r = '{st: imq_pkg::ST_OK, id: hp_id[pos], key: hp_key[pos], pay: hp_pay[pos]};
        slot_by_id[hp_id[pos]] = 0;
        heap_size = last - 1;
        if (pos != last)
        begin
            hp_key[pos] = hp_key[last];
            hp_id[pos] = hp_id[last];
            hp_pay[pos] = hp_pay[last];
            slot_by_id[hp_id[pos]] = pos;
            reheap_at(pos);
        end
        return r;
    endfunction

    function automatic status_word_t heap_request(fn_t fn, id_t id, key_t key, pay_t pay);
        status_word_t r;
        int unsigned limit;
        int unsigned pos;
        r = '{st: imq_pkg::ST_OK, id: '0, key: '0, pay: '0};
        limit = (cap_reg > HEAP_CAP) ? HEAP_CAP : cap_reg;
        pos = slot_by_id[id];
        case (fn)
            imq_pkg::FN_INSERT:
                if (heap_size >= limit)
                    r.st = imq_pkg::ST_FULL;
                else if (pos != 0)
                    r.st = imq_pkg::ST_PRESENT;
                else
                begin
                    heap_size++;
                    hp_key[heap_size] = key;
                    hp_id[heap_size] = id;
                    hp_pay[heap_size] = pay;
                    slot_by_id[id] = heap_size;
                    bubble_up(heap_size);
                end
            imq_pkg::FN_DEL_MIN:
                if (heap_size == 0)
                    r.st = imq_pkg::ST_EMPTY;
                else
                    r = extract_slot(1);
            imq_pkg::FN_SET_KEY:
                if (pos == 0 || pos > heap_size)
                    r.st = imq_pkg::ST_NOTFOUND;
                else
                begin
                    hp_key[pos] = key;
                    reheap_at(pos);
                end
            default:
                if (pos == 0 || pos > heap_size)
                    r.st = imq_pkg::ST_NOTFOUND;
                else
                    r = extract_slot(pos);
        endcase
        return r;
    endfunction

    // One request: hold it until the transfer, then predict.
    task automatic send_request(fn_t fn, id_t id, key_t key, pay_t pay,
                                bit known, status_word_t typed);
        status_word_t r;
        in_valid <= 1'b1;
        func <= fn;
        entry_id <= id;
        entry_key <= key;
        entry_payload <= pay;
        do
            @(posedge clk);
        while (in_stall);
        transfers_in++;
        r = heap_request(fn, id, key, pay);
        if (known && r !== typed)
            $display("directed row disagrees with predictor: %h vs %h", typed, r);
        pending_status.push_back(known ? typed : r);
    endtask

    task automatic pause_sender();
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    // Wait for all results, then a margin for the sequencer, then write the limit.
    task automatic write_limit(int unsigned value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value[imq_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cap_reg = value;
    endtask

    function automatic key_t pick_key();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 15) - 8;
            default: return $urandom();
        endcase
    endfunction

    // Ids mostly from a small pool so that hits are common.
    function automatic id_t pick_id(int unsigned pool);
        if ($urandom_range(0, 9) == 0)
            return id_t'($urandom());
        return id_t'($urandom_range(0, pool - 1));
    endfunction

    task automatic random_phase(int unsigned count, int unsigned pool, int unsigned ins_weight);
        int unsigned burst;
        int unsigned w;
        fn_t fn;
        id_t id;
        burst = 0;
        for (int n = 0; n < count; n++)
        begin
            if (burst == 0)
            begin
                pause_sender();
                burst = $urandom_range(1, 30);
            end
            burst--;
            w = $urandom_range(0, 99);
            if (w < ins_weight)
                fn = imq_pkg::FN_INSERT;
            else if (w < ins_weight + (100 - ins_weight) / 3)
                fn = imq_pkg::FN_DEL_MIN;
            else if (w < ins_weight + 2 * (100 - ins_weight) / 3)
                fn = imq_pkg::FN_SET_KEY;
            else
                fn = imq_pkg::FN_REMOVE;
            // Set key and remove usually aim at a present entry.
            if ((fn == imq_pkg::FN_SET_KEY || fn == imq_pkg::FN_REMOVE) && heap_size != 0
                && $urandom_range(0, 3) != 0)
                id = hp_id[$urandom_range(1, heap_size)];
            else
                id = pick_id(pool);
            send_request(fn, id, pick_key(), $urandom(), 1'b0, '0);
        end
    endtask

    function automatic void add_row(fn_t fn, id_t id, key_t key, pay_t pay,
                                    bit known, st_t st, id_t oid, key_t okey,
                                    pay_t opay);
        request_row_t row;
        row = '{fn: fn, id: id, key: key, pay: pay, known: known,
                res: '{st: st, id: oid, key: okey, pay: opay}};
        directed_rows.push_back(row);
    endfunction

    // Receiver: stall pattern changes from stretch to stretch.
    initial
    begin
        int unsigned mode;
        int unsigned run;
        mode = 0;
        run = 0;
        forever
        begin
            @(posedge clk);
            if (run == 0)
            begin
                mode = $urandom_range(0, 3);
                run = $urandom_range(20, 200);
            end
            run--;
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 1) == 0);
                default: out_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Checker of output transfers.
    always @(posedge clk)
    begin
        status_word_t got;
        status_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{st: status, id: out_id, key: out_key, pay: out_payload};
            transfers_out++;
            if (pending_status.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer %h", got);
            end
            else
            begin
                want = pending_status.pop_front();
                if (got.st !== want.st || got.id !== want.id || got.key !== want.key
                    || got.pay !== want.pay)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected st=%0d id=%0d key=%0d pay=%h, got st=%0d id=%0d key=%0d pay=%h",
                                 want.st, want.id, $signed(want.key), want.pay,
                                 got.st, got.id, $signed(got.key), got.pay);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", pending_status.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        request_row_t row;
        for (int i = 0; i < IDS; i++)
            slot_by_id[i] = 0;
        heap_size = 0;
        cap_reg = 256;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: empty cases, extremes of key, id and payload, and the
        // empty, not-found and present failure statuses.
        add_row(imq_pkg::FN_DEL_MIN, 10'd0, '0, '0, 1, imq_pkg::ST_EMPTY, '0, '0, '0);
        add_row(imq_pkg::FN_SET_KEY, 10'd5, '0, '0, 1, imq_pkg::ST_NOTFOUND, '0, '0, '0);
        add_row(imq_pkg::FN_REMOVE, 10'd1023, '0, '0, 1, imq_pkg::ST_NOTFOUND, '0, '0, '0);
        add_row(imq_pkg::FN_INSERT, 10'd1023, 32'h7fff_ffff, 32'hffff_ffff, 1,
                imq_pkg::ST_OK, '0, '0, '0);
        add_row(imq_pkg::FN_INSERT, 10'd0, 32'h8000_0000, 32'h0000_0000, 1,
                imq_pkg::ST_OK, '0, '0, '0);
        add_row(imq_pkg::FN_INSERT, 10'd0, 32'd1, 32'd1, 1, imq_pkg::ST_PRESENT, '0, '0, '0);
        add_row(imq_pkg::FN_INSERT, 10'd512, 32'hffff_ffff, 32'h5555_aaaa, 1,
                imq_pkg::ST_OK, '0, '0, '0);
        add_row(imq_pkg::FN_INSERT, 10'd341, 32'd0, 32'haaaa_5555, 0,
                imq_pkg::ST_OK, '0, '0, '0);
        add_row(imq_pkg::FN_DEL_MIN, 10'd0, '0, '0, 1, imq_pkg::ST_OK,
                10'd0, 32'h8000_0000, 32'h0);
        add_row(imq_pkg::FN_SET_KEY, 10'd1023, 32'h8000_0000, '0, 0,
                imq_pkg::ST_OK, '0, '0, '0);
        add_row(imq_pkg::FN_SET_KEY, 10'd512, 32'h7fff_ffff, '0, 0,
                imq_pkg::ST_OK, '0, '0, '0);
        add_row(imq_pkg::FN_SET_KEY, 10'd341, 32'd7, '0, 0, imq_pkg::ST_OK, '0, '0, '0);
        add_row(imq_pkg::FN_REMOVE, 10'd512, '0, '0, 0, imq_pkg::ST_OK, '0, '0, '0);
        add_row(imq_pkg::FN_REMOVE, 10'd341, '0, '0, 0, imq_pkg::ST_OK, '0, '0, '0);
        add_row(imq_pkg::FN_DEL_MIN, 10'd0, '0, '0, 1, imq_pkg::ST_OK,
                10'd1023, 32'h8000_0000, 32'hffff_ffff);
        add_row(imq_pkg::FN_DEL_MIN, 10'd0, '0, '0, 1, imq_pkg::ST_EMPTY, '0, '0, '0);
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_request(row.fn, row.id, row.key, row.pay, row.known, row.res);
        end

        // Limit of one, then zero: full before present.
        write_limit(1);
        send_request(imq_pkg::FN_INSERT, 10'd9, 32'd3, 32'd3, 1,
                     '{imq_pkg::ST_OK, '0, '0, '0});
        send_request(imq_pkg::FN_INSERT, 10'd9, 32'd3, 32'd3, 1,
                     '{imq_pkg::ST_FULL, '0, '0, '0});
        write_limit(0);
        send_request(imq_pkg::FN_DEL_MIN, 10'd0, '0, '0, 1,
                     '{imq_pkg::ST_OK, 10'd9, 32'd3, 32'd3});
        send_request(imq_pkg::FN_INSERT, 10'd4, 32'd1, 32'd1, 1,
                     '{imq_pkg::ST_FULL, '0, '0, '0});

        // Random phases under several limits; the limit above capacity acts as
        // capacity and is filled by the insert-heavy phase.
        write_limit(511);
        random_phase(600, 1024, 80);
        write_limit(256);
        random_phase(300, 64, 45);
        write_limit(5);
        random_phase(250, 16, 50);
        write_limit(1);
        random_phase(100, 8, 50);
        write_limit(40);
        random_phase(500, 128, 55);

        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("requests sent %0d, results checked %0d, mismatches %0d",
                 transfers_in, transfers_out, mismatches);
        $display("covered all four operations, every status code and limits 0 to 511");
        if (mismatches == 0 && pending_status.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
design/imq_pkg.sv
design/imq_ram.sv
design/indexed_min_priority_queue.sv
tb/sv/testbench.sv
